// ===== sv/sbsc_pkg.sv =====
// Shared types and constants for the segment box slab clip block.
// No dependencies; imported by every module of the block.
package sbsc_pkg;

   localparam int EPS_SCALED = 1;
   localparam logic [16:0] ONE_Q16 = 17'd65536;
   localparam logic [17:0] SAT_Q16 = 18'd131072;
   localparam logic [17:0] SCALE_LO = 18'(65536 - EPS_SCALED);
   localparam logic [17:0] SCALE_HI = 18'(65536 + EPS_SCALED);
   localparam int QUOT_BITS = 18;
   localparam int DIV_STAGES = QUOT_BITS + 1;

   typedef enum logic [2:0] {
      CSR_BOX_MIN_X = 3'd0,
      CSR_BOX_MIN_Y = 3'd1,
      CSR_BOX_MAX_X = 3'd2,
      CSR_BOX_MAX_Y = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [16:0] entry_frac;
      logic [16:0] exit_frac;
   } rsp_type;

endpackage

// ===== sv/sbsc_div.sv =====
// Pipelined restoring divider: quotient of magnitudes, one bit per stage, saturating, sign applied at the output.
// Depends on sbsc_pkg for the quotient width and saturation limit.
module sbsc_div
   import sbsc_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic [48:0]        num_mag,
   input  logic [31:0]        den_mag,
   input  logic               neg,
   output logic signed [18:0] quot
);

   logic [48:0]           r_ff   [0:QUOT_BITS];
   logic [31:0]           d_ff   [0:QUOT_BITS];
   logic [QUOT_BITS-1:0]  q_ff   [0:QUOT_BITS];
   logic                  neg_ff [0:QUOT_BITS];
   logic                  ovf_ff [0:QUOT_BITS];
   logic [17:0]           mag;

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]   <= num_mag;
         d_ff[0]   <= den_mag;
         q_ff[0]   <= '0;
         neg_ff[0] <= neg;
         ovf_ff[0] <= {1'b0, num_mag} >= {den_mag, 18'd0};
      end
   end

   for (genvar k = 1; k <= QUOT_BITS; k++) begin : g_stage
      localparam int BIT = QUOT_BITS - k;
      logic [49:0] sh;
      logic        ge;
      assign sh = 50'(d_ff[k-1]) << BIT;
      assign ge = {1'b0, r_ff[k-1]} >= sh;
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k]   <= ge ? r_ff[k-1] - sh[48:0] : r_ff[k-1];
            d_ff[k]   <= d_ff[k-1];
            q_ff[k]   <= q_ff[k-1] | (ge ? QUOT_BITS'(1) << BIT : '0);
            neg_ff[k] <= neg_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign mag  = (ovf_ff[QUOT_BITS] || q_ff[QUOT_BITS] > SAT_Q16) ? SAT_Q16 : q_ff[QUOT_BITS];
   assign quot = neg_ff[QUOT_BITS] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

// ===== sv/segment_box_slab_clip.sv =====
// Segment against box slab clip: top level with box registers and pipeline.
// Depends on sbsc_pkg and sbsc_div.
// One segment enters per cycle unless the pipeline is stalled; a result passes through
// the input, difference, multiply, magnitude and overflow stages, the 18 one-bit stages
// of the four parallel dividers and the combining output stage.
// A stalled result freezes the whole pipeline.
module segment_box_slab_clip
   import sbsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic signed [31:0] box_lo_ff [0:1];
   logic signed [31:0] box_hi_ff [0:1];
   logic en;

   logic               a_valid_ff;
   logic signed [31:0] a_p_ff [0:1];
   logic signed [31:0] a_q_ff [0:1];

   logic               b_valid_ff;
   logic signed [32:0] b_d_ff [0:1];
   logic signed [32:0] b_near_ff [0:1];
   logic signed [32:0] b_far_ff [0:1];
   logic               b_zero_ff [0:1];
   logic               b_inside_ff [0:1];

   logic               c_valid_ff;
   logic signed [32:0] c_d_ff [0:1];
   logic signed [49:0] c_ns_ff [0:1];
   logic signed [49:0] c_nt_ff [0:1];
   logic               c_zero_ff [0:1];
   logic               c_inside_ff [0:1];

   logic               d_valid_ff;
   logic [48:0]        d_ns_ff [0:1];
   logic [48:0]        d_nt_ff [0:1];
   logic [31:0]        d_den_ff [0:1];
   logic               d_negs_ff [0:1];
   logic               d_negt_ff [0:1];
   logic               d_zero_ff [0:1];
   logic               d_inside_ff [0:1];

   logic               v_ff      [0:DIV_STAGES-1];
   logic [1:0]         zero_ff   [0:DIV_STAGES-1];
   logic [1:0]         inside_ff [0:DIV_STAGES-1];

   logic signed [18:0] qs [0:1];
   logic signed [18:0] qt [0:1];
   logic signed [18:0] s_in;
   logic signed [18:0] t_in;
   logic               hit_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_lo_ff[0] <= '0;
         box_lo_ff[1] <= '0;
         box_hi_ff[0] <= '0;
         box_hi_ff[1] <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BOX_MIN_X: box_lo_ff[0] <= csr_data;
            CSR_BOX_MIN_Y: box_lo_ff[1] <= csr_data;
            CSR_BOX_MAX_X: box_hi_ff[0] <= csr_data;
            CSR_BOX_MAX_Y: box_hi_ff[1] <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < DIV_STAGES; k++) v_ff[k] <= 1'b0;
      end else if (en) begin
         a_valid_ff   <= req_valid;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         d_valid_ff   <= c_valid_ff;
         v_ff[0]      <= d_valid_ff;
         for (int k = 1; k < DIV_STAGES; k++) v_ff[k] <= v_ff[k-1];
         rsp_valid_ff <= v_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_p_ff[0] <= req_payload.start_x;
         a_p_ff[1] <= req_payload.start_y;
         a_q_ff[0] <= req_payload.end_x;
         a_q_ff[1] <= req_payload.end_y;
         for (int a = 0; a < 2; a++) begin
            b_d_ff[a]      <= 33'(a_q_ff[a]) - 33'(a_p_ff[a]);
            b_near_ff[a]   <= (a_q_ff[a] > a_p_ff[a]) ? 33'(box_lo_ff[a]) - 33'(a_p_ff[a])
                                                      : 33'(box_hi_ff[a]) - 33'(a_p_ff[a]);
            b_far_ff[a]    <= (a_q_ff[a] > a_p_ff[a]) ? 33'(box_hi_ff[a]) - 33'(a_p_ff[a])
                                                      : 33'(box_lo_ff[a]) - 33'(a_p_ff[a]);
            b_zero_ff[a]   <= a_q_ff[a] == a_p_ff[a];
            b_inside_ff[a] <= (a_p_ff[a] >= box_lo_ff[a]) && (a_p_ff[a] <= box_hi_ff[a]);

            c_d_ff[a]      <= b_d_ff[a];
            c_ns_ff[a]     <= 50'(b_near_ff[a]) * 50'($signed(SCALE_LO));
            c_nt_ff[a]     <= 50'(b_far_ff[a]) * 50'($signed(SCALE_HI));
            c_zero_ff[a]   <= b_zero_ff[a];
            c_inside_ff[a] <= b_inside_ff[a];

            d_ns_ff[a]     <= c_ns_ff[a][49] ? 49'(-c_ns_ff[a]) : c_ns_ff[a][48:0];
            d_nt_ff[a]     <= c_nt_ff[a][49] ? 49'(-c_nt_ff[a]) : c_nt_ff[a][48:0];
            d_den_ff[a]    <= c_d_ff[a][32] ? 32'(-c_d_ff[a]) : c_d_ff[a][31:0];
            d_negs_ff[a]   <= c_ns_ff[a][49] ^ c_d_ff[a][32];
            d_negt_ff[a]   <= c_nt_ff[a][49] ^ c_d_ff[a][32];
            d_zero_ff[a]   <= c_zero_ff[a];
            d_inside_ff[a] <= c_inside_ff[a];
         end
         zero_ff[0]   <= {d_zero_ff[1], d_zero_ff[0]};
         inside_ff[0] <= {d_inside_ff[1], d_inside_ff[0]};
         for (int k = 1; k < DIV_STAGES; k++) begin
            zero_ff[k]   <= zero_ff[k-1];
            inside_ff[k] <= inside_ff[k-1];
         end
         rsp_ff.hit        <= hit_in;
         rsp_ff.entry_frac <= hit_in ? s_in[16:0] : '0;
         rsp_ff.exit_frac  <= hit_in ? t_in[16:0] : '0;
      end
   end

   for (genvar a = 0; a < 2; a++) begin : g_axis
      sbsc_div u_div_s (
         .clock   (clock),
         .en      (en),
         .num_mag (d_ns_ff[a]),
         .den_mag (d_den_ff[a]),
         .neg     (d_negs_ff[a]),
         .quot    (qs[a])
      );
      sbsc_div u_div_t (
         .clock   (clock),
         .en      (en),
         .num_mag (d_nt_ff[a]),
         .den_mag (d_den_ff[a]),
         .neg     (d_negt_ff[a]),
         .quot    (qt[a])
      );
   end

   always_comb begin
      logic [1:0] zr;
      logic [1:0] ins;
      zr   = zero_ff[DIV_STAGES-1];
      ins  = inside_ff[DIV_STAGES-1];
      s_in = '0;
      t_in = $signed(19'(ONE_Q16));
      for (int a = 0; a < 2; a++) begin
         if (!zr[a] && qs[a] > s_in) s_in = qs[a];
         if (!zr[a] && qt[a] < t_in) t_in = qt[a];
      end
      hit_in = (!zr[0] || ins[0]) && (!zr[1] || ins[1]) && (s_in <= t_in);
   end

endmodule

// ===== test/tb.sv =====
// Testbench for segment_box_slab_clip: drives segments against several box settings
// and checks every clip result against a built-in slab-test predictor.
// Depends on sbsc_pkg and the segment_box_slab_clip RTL.
module tb;
   import sbsc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   class clip_scoreboard;
      logic signed [31:0] box_lo_x, box_lo_y, box_hi_x, box_hi_y;
      rsp_type pending[$];
      int mismatches;

      function new();
         box_lo_x = 0; box_lo_y = 0; box_hi_x = 0; box_hi_y = 0;
         mismatches = 0;
      endfunction

      function void set_box(csr_index_type idx, logic [31:0] v);
         case (idx)
            CSR_BOX_MIN_X: box_lo_x = v;
            CSR_BOX_MIN_Y: box_lo_y = v;
            CSR_BOX_MAX_X: box_hi_x = v;
            CSR_BOX_MAX_Y: box_hi_y = v;
            default: ;
         endcase
      endfunction

      function longint sat_quot(longint scale, longint diff, longint d);
         longint q;
         q = (scale * diff) / d;
         if (q > longint'(SAT_Q16)) q = SAT_Q16;
         if (q < -longint'(SAT_Q16)) q = -longint'(SAT_Q16);
         return q;
      endfunction

      function bit narrow(longint p, longint q, longint lo_b, longint hi_b,
                          inout longint s, inout longint t);
         longint d, s0, t0, lo, hi;
         lo = 65536 - EPS_SCALED;
         hi = 65536 + EPS_SCALED;
         d = q - p;
         if (d == 0) return !(p < lo_b || p > hi_b);
         if (d > 0) begin
            s0 = sat_quot(lo, lo_b - p, d);
            t0 = sat_quot(hi, hi_b - p, d);
         end else begin
            s0 = sat_quot(lo, hi_b - p, d);
            t0 = sat_quot(hi, lo_b - p, d);
         end
         if (s0 > s) s = s0;
         if (t0 < t) t = t0;
         return s <= t;
      endfunction

      function void note_segment(req_type r);
         longint s, t;
         bit h;
         rsp_type e;
         s = 0;
         t = 65536;
         h = narrow(r.start_x, r.end_x, box_lo_x, box_hi_x, s, t);
         if (h) h = narrow(r.start_y, r.end_y, box_lo_y, box_hi_y, s, t);
         e.hit = h;
         e.entry_frac = h ? s[16:0] : 17'd0;
         e.exit_frac = h ? t[16:0] : 17'd0;
         pending.push_back(e);
      endfunction

      function void check_clip(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", a);
            return;
         end
         e = pending.pop_front();
         if (a.hit !== e.hit || a.entry_frac !== e.entry_frac
             || a.exit_frac !== e.exit_frac) begin
            mismatches++;
            if (mismatches <= 10) $display("expected %p actual %p", e, a);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall, rsp_valid, rsp_stall = 0;
   req_type req_payload = '0;
   rsp_type rsp_payload;
   logic csr_valid = 0, csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   clip_scoreboard board = new();
   int cycles = 0;
   bit idle_on = 1, hold_rsp = 0, done = 0;

   segment_box_slab_clip dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 400000) begin
         $display("Mismatches found");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) board.check_clip(rsp_payload);
   end

   // receiver stall in bursts
   initial begin
      int n;
      @(negedge clock);
      while (!done) begin
         if (hold_rsp) begin
            rsp_stall <= 1;
            repeat (60) @(negedge clock);
            hold_rsp = 0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 12);
            rsp_stall <= 1;
            repeat (n) @(negedge clock);
         end else begin
            rsp_stall <= 0;
            @(negedge clock);
         end
      end
      rsp_stall <= 0;
   end

   task automatic write_box(csr_index_type idx, logic [31:0] v);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.set_box(idx, v);
      @(negedge clock);
   endtask

   task automatic set_all(logic [31:0] lx, logic [31:0] ly, logic [31:0] hx, logic [31:0] hy);
      write_box(CSR_BOX_MIN_X, lx);
      write_box(CSR_BOX_MIN_Y, ly);
      write_box(CSR_BOX_MAX_X, hx);
      write_box(CSR_BOX_MAX_Y, hy);
      csr_valid <= 0;
   endtask

   task automatic send_segment(req_type r);
      int n;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, 12);
         req_valid <= 0;
         repeat (n) @(negedge clock);
      end
      req_valid <= 1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_segment(r);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   function automatic logic [31:0] coord(logic signed [31:0] lo, logic signed [31:0] hi);
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return $urandom;
      if (r == 1) return (r[0] ? lo : hi);
      return lo + $signed($urandom_range(0, 32'(hi - lo) * 2 + 1)) - (hi - lo) / 2;
   endfunction

   function automatic req_type rand_segment(logic signed [31:0] lo, logic signed [31:0] hi);
      req_type r;
      r.start_x = coord(lo, hi);
      r.start_y = coord(lo, hi);
      r.end_x = ($urandom_range(0, 7) == 0) ? r.start_x : coord(lo, hi);
      r.end_y = ($urandom_range(0, 7) == 0) ? r.start_y : coord(lo, hi);
      return r;
   endfunction

   initial begin
      req_type r;
      logic signed [31:0] lo, hi;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: default zero box, then a box from 0x1_0000 to 0x3_0000 on both axes
      send_segment('{32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000});
      send_segment('{0, 0, 0, 0});
      drain();
      set_all(32'sh0001_0000, 32'sh0001_0000, 32'sh0003_0000, 32'sh0003_0000);
      send_segment('{0, 0, 32'sh0004_0000, 32'sh0004_0000});
      send_segment('{32'sh0004_0000, 32'sh0004_0000, 0, 0});
      send_segment('{32'sh0002_0000, 0, 32'sh0002_0000, 32'sh0004_0000});
      send_segment('{32'sh0005_0000, 0, 32'sh0005_0000, 32'sh0004_0000});
      send_segment('{0, 32'sh0002_0000, 32'sh0004_0000, 32'sh0002_0000});
      send_segment('{32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000});
      send_segment('{32'sh0003_0000, 32'sh0001_0000, 32'sh0003_0000, 32'sh0001_0000});
      send_segment('{0, 0, 32'sh0000_8000, 32'sh0000_8000});
      send_segment('{32'sh0002_0000, 32'sh0002_0000, 32'sh0008_0000, 32'sh0002_0001});
      send_segment('{32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff});
      send_segment('{32'sh7fff_ffff, 32'sh0002_0000, 32'sh8000_0000, 32'sh0002_0000});
      send_segment('{32'shffff_ffff, 32'sh0000_0001, 32'sh5555_5555, 32'shaaaa_aaaa});
      drain();
      // inverted box, then extreme box
      set_all(32'sh0003_0000, 32'sh0003_0000, 32'sh0001_0000, 32'sh0001_0000);
      send_segment('{0, 0, 32'sh0004_0000, 32'sh0004_0000});
      send_segment('{32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000});
      drain();
      set_all(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff);
      send_segment('{32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff});
      send_segment('{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000});
      drain();
      // random phases over several boxes
      for (int ph = 0; ph < 8; ph++) begin
         lo = $urandom_range(0, 3) == 0 ? $urandom : -$signed($urandom_range(1, 1 << 20));
         hi = (ph == 5) ? lo - 100 : lo + $urandom_range(1, 1 << 21);
         if (ph == 7) begin
            lo = 32'sh8000_0000;
            hi = 32'sh7fff_ffff;
         end
         set_all(lo, lo + $urandom_range(0, 4096), hi, hi - $urandom_range(0, 4096));
         if (ph == 2) hold_rsp = 1;
         if (ph == 7) idle_on = 0;
         for (int i = 0; i < 100; i++) begin
            r = rand_segment(lo, hi);
            send_segment(r);
            if (ph == 3 && i == 50) drain();
         end
         drain();
      end
      done = 1;
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

// ===== segment_box_slab_clip.f =====
sv/sbsc_pkg.sv
sv/sbsc_div.sv
sv/segment_box_slab_clip.sv
test/tb.sv
